@@ rtl/core/esst_pkg.sv @@
package esst_pkg;

   localparam int KEY_W  = 193;
   localparam int CNT_W  = 224;
   localparam int SEQ_W  = 32;

   // bucket count; the bucket index is a bit slice of the hash, so a power of two
   localparam int BUCKETS = 256;

   typedef enum logic [1:0] {
      ST_FOUND    = 2'd0,
      ST_INSERTED = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      VD_GOOD = 2'd0,
      VD_FWD  = 2'd1,
      VD_BACK = 2'd2,
      VD_NONE = 2'd3
   } verdict_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HEAD,
      S_WALK,
      S_CMP,
      S_UPD,
      S_OUT
   } state_type;

   localparam logic [0:0] CSR_MAX_ENTRIES = 1'b0;
   localparam logic [0:0] CSR_DISABLE     = 1'b1;

   // key: {is_v6, addr_high, addr_low, ident_two, ident_one}
   typedef struct packed {
      logic        is_v6;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [63:0] ident;
   } key_type;

   // counters stored per entry
   typedef struct packed {
      logic [63:0] packets;
      logic [63:0] bytes;
      logic [31:0] good;
      logic [31:0] fwd;
      logic [31:0] back;
   } cnt_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  entry_index;
      logic [1:0]  verdict;
      logic [31:0] expected_seq;
      cnt_type     cnt;
   } rsp_type;

endpackage

@@ rtl/core/esst_if.sv @@
interface esst_req_if;
   logic        valid;
   logic        ready;
   logic        is_v6;
   logic [63:0] addr_high;
   logic [63:0] addr_low;
   logic [31:0] ident_one;
   logic [31:0] ident_two;
   logic [31:0] hash_salt;
   logic [31:0] seq_number;
   logic [31:0] byte_count;
   logic [31:0] seq_increment;
   modport source (output valid, is_v6, addr_high, addr_low, ident_one, ident_two,
                   hash_salt, seq_number, byte_count, seq_increment, input ready);
   modport sink (input valid, is_v6, addr_high, addr_low, ident_one, ident_two,
                 hash_salt, seq_number, byte_count, seq_increment, output ready);
endinterface

interface esst_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  entry_index;
   logic [1:0]  verdict;
   logic [31:0] expected_seq;
   logic [63:0] packet_total;
   logic [63:0] byte_total;
   logic [31:0] good_total;
   logic [31:0] forward_jumps;
   logic [31:0] backward_jumps;
   modport source (output valid, status, entry_index, verdict, expected_seq,
                   packet_total, byte_total, good_total, forward_jumps,
                   backward_jumps, input ready);
   modport sink (input valid, status, entry_index, verdict, expected_seq,
                 packet_total, byte_total, good_total, forward_jumps,
                 backward_jumps, output ready);
endinterface

@@ rtl/core/exporter_seq_status_table.sv @@
// Steps: after acceptance the bucket head is read; a hit at the chain head is compared and
// updated, a miss on an empty bucket is allocated and updated; each further chain entry
// adds a compare step, a miss after a chain walk adds the allocation step, and a full
// table is reported from the allocation step. One word at a time: the block is ready for
// the next word in the cycle after the result is taken.
// Reset: synchronous; clears bucket valid bits, entry count and disable bit, sets the
// entry limit to 256; entry memories need no clearing, a new entry's link ends its chain.
module exporter_seq_status_table #(
   parameter int ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   esst_req_if.sink    req,
   esst_rsp_if.source  rsp,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [8:0]  csr_wr_data
);
   localparam int BW = (esst_pkg::BUCKETS > 1) ? $clog2(esst_pkg::BUCKETS) : 1;
   localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   esst_pkg::state_type state_ff, state_in;
   logic [8:0] max_entries_ff;
   logic       disable_ff;
   logic [CW-1:0] used_ff, used_in;
   logic [esst_pkg::BUCKETS-1:0] bvalid_ff, bvalid_in;

   // held request word
   esst_pkg::key_type key_ff, key_in;
   logic [BW-1:0] bucket_ff, bucket_in;
   logic [31:0] seq_ff, inc_ff, bytes_ff;
   logic [EW-1:0] e_ff, e_in;
   logic          new_ff, new_in;
   esst_pkg::rsp_type out_ff, out_in;

   // memories; the link memory holds {link valid, next slot}
   logic          hd_we;  logic [EW-1:0] hd_wd, hd_rd;
   logic          nx_we;  logic [EW-1:0] nx_wa;  logic [EW:0] nx_wd, nx_rd;
   logic          k_we;   esst_pkg::key_type k_rd;
   logic          c_we;   esst_pkg::cnt_type c_wd, c_rd;
   logic [31:0]   s_rd;
   logic [EW-1:0] rd_e;

   esst_ram #(.WIDTH(EW), .DEPTH(esst_pkg::BUCKETS)) u_head (.clock, .wr_en(hd_we),
      .wr_addr(bucket_ff), .wr_data(hd_wd), .rd_addr(bucket_in), .rd_data(hd_rd));
   esst_ram #(.WIDTH(EW + 1), .DEPTH(ENTRIES)) u_next (.clock, .wr_en(nx_we),
      .wr_addr(nx_wa), .wr_data(nx_wd), .rd_addr(rd_e), .rd_data(nx_rd));
   esst_ram #(.WIDTH(esst_pkg::KEY_W), .DEPTH(ENTRIES)) u_key (.clock,
      .wr_en(k_we), .wr_addr(e_ff), .wr_data(key_ff), .rd_addr(rd_e), .rd_data(k_rd));
   esst_ram #(.WIDTH(esst_pkg::CNT_W), .DEPTH(ENTRIES)) u_cnt (.clock,
      .wr_en(c_we), .wr_addr(e_ff), .wr_data(c_wd), .rd_addr(rd_e), .rd_data(c_rd));
   esst_ram #(.WIDTH(esst_pkg::SEQ_W), .DEPTH(ENTRIES)) u_seq (.clock,
      .wr_en(c_we), .wr_addr(e_ff), .wr_data(seq_ff), .rd_addr(rd_e), .rd_data(s_rd));

   // update datapath; new entries start from cleared values
   esst_pkg::cnt_type cnt_old, cnt_new;
   logic [31:0] seq_old, expect_seq;
   esst_pkg::verdict_type verdict;
   assign cnt_old = new_ff ? '0 : c_rd;
   assign seq_old = new_ff ? '0 : s_rd;

   esst_update u_upd (.disable_checks(disable_ff), .cnt_old, .seq_old,
      .seq_number(seq_ff), .seq_increment(inc_ff), .byte_count(bytes_ff),
      .cnt_new, .expect_seq, .verdict);

   logic [CW-1:0] limit;
   assign limit = ({23'd0, max_entries_ff} < ENTRIES) ? CW'(max_entries_ff) : CW'(ENTRIES);

   esst_pkg::key_type req_key;
   always_comb begin
      req_key.is_v6 = req.is_v6;
      req_key.addr_high = req.is_v6 ? req.addr_high : '0;
      req_key.addr_low = req.is_v6 ? req.addr_low : {32'd0, req.addr_low[31:0]};
      req_key.ident = {req.ident_two, req.ident_one};
   end

   assign req.ready = (state_ff == esst_pkg::S_IDLE);
   assign rsp.valid = (state_ff == esst_pkg::S_OUT);

   // sequencer: head read, chain walk, allocation on a miss, read-modify-write, result
   always_comb begin
      state_in = state_ff; key_in = key_ff; bucket_in = bucket_ff; e_in = e_ff;
      new_in = new_ff; out_in = out_ff; used_in = used_ff;
      bvalid_in = bvalid_ff;
      hd_we = 1'b0; hd_wd = e_ff; nx_we = 1'b0; nx_wa = e_ff; nx_wd = {1'b0, e_ff};
      k_we = 1'b0; c_we = 1'b0; c_wd = cnt_new; rd_e = e_ff;
      unique case (state_ff)
         esst_pkg::S_IDLE: begin
            if (req.valid) begin
               key_in = req_key;
               bucket_in = BW'(req.hash_salt ^ req.addr_low[31:0]);
               state_in = esst_pkg::S_HEAD;
            end
         end
         esst_pkg::S_HEAD: begin
            if (bvalid_ff[bucket_ff]) begin
               rd_e = hd_rd; e_in = hd_rd; state_in = esst_pkg::S_CMP;
            end else begin
               state_in = esst_pkg::S_WALK; new_in = 1'b1;
            end
         end
         esst_pkg::S_CMP: begin
            if (k_rd == key_ff) begin
               new_in = 1'b0; state_in = esst_pkg::S_UPD;
            end else if (nx_rd[EW]) begin
               rd_e = nx_rd[EW-1:0]; e_in = nx_rd[EW-1:0];
            end else begin
               new_in = 1'b1; state_in = esst_pkg::S_WALK;
            end
         end
         esst_pkg::S_WALK: begin
            // miss: allocate at tail (e_ff is tail if chain nonempty)
            if (used_ff >= limit) begin
               out_in = '0;
               out_in.status = esst_pkg::ST_FULL;
               out_in.verdict = esst_pkg::VD_NONE;
               state_in = esst_pkg::S_OUT;
            end else begin
               if (bvalid_ff[bucket_ff]) begin
                  nx_we = 1'b1; nx_wa = e_ff; nx_wd = {1'b1, EW'(used_ff)};
               end else begin
                  hd_we = 1'b1; hd_wd = EW'(used_ff);
                  bvalid_in[bucket_ff] = 1'b1;
               end
               e_in = EW'(used_ff);
               used_in = used_ff + CW'(1);
               state_in = esst_pkg::S_UPD;
            end
         end
         esst_pkg::S_UPD: begin
            k_we = new_ff; c_we = 1'b1;
            // a new entry ends its chain
            nx_we = new_ff; nx_wa = e_ff; nx_wd = '0;
            out_in.status = new_ff ? esst_pkg::ST_INSERTED : esst_pkg::ST_FOUND;
            out_in.entry_index = 8'(e_ff);
            out_in.verdict = verdict;
            out_in.expected_seq = expect_seq;
            out_in.cnt = cnt_new;
            state_in = esst_pkg::S_OUT;
         end
         esst_pkg::S_OUT: begin
            if (rsp.ready) state_in = esst_pkg::S_IDLE;
         end
         default: state_in = esst_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= esst_pkg::S_IDLE;
         max_entries_ff <= 9'd256;
         disable_ff <= 1'b0;
         used_ff <= '0;
         bvalid_ff <= '0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         bvalid_ff <= bvalid_in;
         if (csr_wr_en && csr_index == esst_pkg::CSR_MAX_ENTRIES)
            max_entries_ff <= csr_wr_data;
         if (csr_wr_en && csr_index == esst_pkg::CSR_DISABLE)
            disable_ff <= csr_wr_data[0];
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in; bucket_ff <= bucket_in; e_ff <= e_in;
      new_ff <= new_in; out_ff <= out_in;
      if (state_ff == esst_pkg::S_IDLE && req.valid) begin
         seq_ff <= req.seq_number; inc_ff <= req.seq_increment;
         bytes_ff <= req.byte_count;
      end
   end

   assign rsp.status = out_ff.status;
   assign rsp.entry_index = out_ff.entry_index;
   assign rsp.verdict = out_ff.verdict;
   assign rsp.expected_seq = out_ff.expected_seq;
   assign rsp.packet_total = out_ff.cnt.packets;
   assign rsp.byte_total = out_ff.cnt.bytes;
   assign rsp.good_total = out_ff.cnt.good;
   assign rsp.forward_jumps = out_ff.cnt.fwd;
   assign rsp.backward_jumps = out_ff.cnt.back;

   a_used_limit: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(ENTRIES)) else $error("entry count overflow");
   a_full_no_alloc: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == esst_pkg::ST_FULL) |-> $stable(used_ff))
      else $error("allocation on full table");
   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == esst_pkg::S_UPD && new_ff) |-> (used_ff != '0))
      else $error("insert without allocation");
endmodule

@@ rtl/core/esst_ram.sv @@
module esst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

@@ rtl/core/esst_update.sv @@
// Counter update and sequence classification for one entry.
module esst_update (
   input  logic                 disable_checks,
   input  esst_pkg::cnt_type    cnt_old,
   input  logic [31:0]          seq_old,
   input  logic [31:0]          seq_number,
   input  logic [31:0]          seq_increment,
   input  logic [31:0]          byte_count,
   output esst_pkg::cnt_type    cnt_new,
   output logic [31:0]          expect_seq,
   output esst_pkg::verdict_type verdict
);
   always_comb begin
      expect_seq = seq_old + seq_increment;
      cnt_new = cnt_old;
      cnt_new.packets = cnt_old.packets + 64'd1;
      cnt_new.bytes = cnt_old.bytes + {32'd0, byte_count};
      if (seq_old == '0 || disable_checks || seq_number == expect_seq) begin
         cnt_new.good = cnt_old.good + 32'd1;
         verdict = esst_pkg::VD_GOOD;
      end else if (seq_number > expect_seq) begin
         cnt_new.fwd = cnt_old.fwd + 32'd1;
         verdict = esst_pkg::VD_FWD;
      end else begin
         cnt_new.back = cnt_old.back + 32'd1;
         verdict = esst_pkg::VD_BACK;
      end
   end
endmodule

@@ test/tb_top.sv @@
module tb_top;

   // one datagram as the sender sees it
   typedef struct {
      bit        is_v6;
      bit [63:0] addr_high;
      bit [63:0] addr_low;
      bit [31:0] ident_one;
      bit [31:0] ident_two;
      bit [31:0] hash_salt;
      bit [31:0] seq_number;
      bit [31:0] byte_count;
      bit [31:0] seq_increment;
   } dgram_t;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic       csr_index;
   logic [8:0] csr_wr_data;

   esst_req_if req_ch ();
   esst_rsp_if rsp_ch ();

   exporter_seq_status_table u_dut (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   dgram_t            send_q[$];
   esst_pkg::rsp_type status_q[$];
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   int      err_count = 0;

   // table mirror
   bit                head_ok[256];
   bit [7:0]          head_slot[256];
   bit                link_ok[256];
   bit [7:0]          link_slot[256];
   esst_pkg::key_type slot_key[256];
   esst_pkg::cnt_type slot_cnt[256];
   bit [31:0]         slot_seq[256];
   int          slots_used = 0;
   int          cap_cfg = 256;
   bit          checks_off = 1'b0;

   // work out the response for one accepted word and update the mirror
   function automatic esst_pkg::rsp_type lookup_update(dgram_t d);
      esst_pkg::key_type k;
      esst_pkg::rsp_type r;
      bit [7:0] bkt;
      bit [7:0] e;
      bit [7:0] tail;
      bit       hit;
      bit       walked;
      bit [31:0] exp_seq;
      int       lim;
      k.is_v6     = d.is_v6;
      k.addr_high = d.is_v6 ? d.addr_high : 64'd0;
      k.addr_low  = d.is_v6 ? d.addr_low : {32'd0, d.addr_low[31:0]};
      k.ident     = {d.ident_two, d.ident_one};
      bkt = d.hash_salt[7:0] ^ d.addr_low[7:0];
      hit = 1'b0;
      walked = 1'b0;
      e = 8'd0;
      tail = 8'd0;
      if (head_ok[bkt]) begin
         e = head_slot[bkt];
         for (int n = 0; n < 256; n++) begin
            walked = 1'b1;
            tail = e;
            if (slot_key[e] == k) begin
               hit = 1'b1;
               break;
            end
            if (!link_ok[e]) break;
            e = link_slot[e];
         end
      end
      r = '0;
      if (hit) begin
         r.status = esst_pkg::ST_FOUND;
      end else begin
         lim = (cap_cfg < 256) ? cap_cfg : 256;
         if (slots_used >= lim) begin
            r.status = esst_pkg::ST_FULL;
            r.verdict = esst_pkg::VD_NONE;
            return r;
         end
         e = slots_used[7:0];
         slot_key[e] = k;
         slot_cnt[e] = '0;
         slot_seq[e] = 32'd0;
         link_ok[e] = 1'b0;
         if (walked) begin
            link_ok[tail] = 1'b1;
            link_slot[tail] = e;
         end else begin
            head_ok[bkt] = 1'b1;
            head_slot[bkt] = e;
         end
         slots_used++;
         r.status = esst_pkg::ST_INSERTED;
      end
      slot_cnt[e].packets += 64'd1;
      slot_cnt[e].bytes += {32'd0, d.byte_count};
      exp_seq = slot_seq[e] + d.seq_increment;
      if (slot_seq[e] == 32'd0 || checks_off || d.seq_number == exp_seq) begin
         slot_cnt[e].good += 32'd1;
         r.verdict = esst_pkg::VD_GOOD;
      end else if (d.seq_number > exp_seq) begin
         slot_cnt[e].fwd += 32'd1;
         r.verdict = esst_pkg::VD_FWD;
      end else begin
         slot_cnt[e].back += 32'd1;
         r.verdict = esst_pkg::VD_BACK;
      end
      slot_seq[e] = d.seq_number;
      r.entry_index = e;
      r.expected_seq = exp_seq;
      r.cnt = slot_cnt[e];
      return r;
   endfunction

   // sender: holds the head word until it is taken
   always @(posedge clock) begin
      bit took;
      took = req_ch.valid && req_ch.ready;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (took) begin
            status_q.push_back(lookup_update(send_q[0]));
            void'(send_q.pop_front());
         end
         if (!req_ch.valid || took) begin
            if (send_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_ch.valid         <= 1'b1;
               req_ch.is_v6         <= send_q[0].is_v6;
               req_ch.addr_high     <= send_q[0].addr_high;
               req_ch.addr_low      <= send_q[0].addr_low;
               req_ch.ident_one     <= send_q[0].ident_one;
               req_ch.ident_two     <= send_q[0].ident_two;
               req_ch.hash_salt     <= send_q[0].hash_salt;
               req_ch.seq_number    <= send_q[0].seq_number;
               req_ch.byte_count    <= send_q[0].byte_count;
               req_ch.seq_increment <= send_q[0].seq_increment;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // receiver: random stalls, compare each taken word
   always @(posedge clock) begin
      esst_pkg::rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (status_q.size() == 0) begin
               $display("%0t: unexpected word status=%0d", $time, rsp_ch.status);
               err_count++;
            end else begin
               want = status_q.pop_front();
               if (rsp_ch.status !== want.status || rsp_ch.entry_index !== want.entry_index
                   || rsp_ch.verdict !== want.verdict
                   || rsp_ch.expected_seq !== want.expected_seq
                   || rsp_ch.packet_total !== want.cnt.packets
                   || rsp_ch.byte_total !== want.cnt.bytes
                   || rsp_ch.good_total !== want.cnt.good
                   || rsp_ch.forward_jumps !== want.cnt.fwd
                   || rsp_ch.backward_jumps !== want.cnt.back) begin
                  $display("%0t: mismatch exp st=%0d ix=%0d vd=%0d es=%h p=%0d b=%0d g=%0d f=%0d k=%0d",
                           $time, want.status, want.entry_index, want.verdict,
                           want.expected_seq, want.cnt.packets, want.cnt.bytes,
                           want.cnt.good, want.cnt.fwd, want.cnt.back);
                  $display("%0t:          act st=%0d ix=%0d vd=%0d es=%h p=%0d b=%0d g=%0d f=%0d k=%0d",
                           $time, rsp_ch.status, rsp_ch.entry_index, rsp_ch.verdict,
                           rsp_ch.expected_seq, rsp_ch.packet_total, rsp_ch.byte_total,
                           rsp_ch.good_total, rsp_ch.forward_jumps, rsp_ch.backward_jumps);
                  err_count++;
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // register write, mirrored at once
   task automatic csr_write(logic idx, logic [8:0] val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      if (idx == esst_pkg::CSR_MAX_ENTRIES) cap_cfg = int'(val);
      else checks_off = val[0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic drain();
      while (send_q.size() > 0 || status_q.size() > 0 || req_ch.valid) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // exporters with live sequence state
   dgram_t flows[64];
   int     flow_cnt = 0;

   function automatic bit [31:0] pick_inc();
      case ($urandom_range(3))
         0: return 32'd0;
         1: return 32'd1;
         2: return $urandom_range(1000);
         default: return $urandom;
      endcase
   endfunction

   function automatic dgram_t fresh_exporter();
      dgram_t d;
      d.is_v6 = 1'($urandom_range(1));
      d.addr_high = {$urandom, $urandom};
      d.addr_low = {$urandom, $urandom};
      d.ident_one = $urandom;
      d.ident_two = $urandom;
      // crowd keys into a few buckets so chains grow
      d.hash_salt = {24'($urandom_range(32'hFFFFFF)),
                     d.addr_low[7:0] ^ 8'($urandom_range(15))};
      d.seq_number = $urandom;
      d.byte_count = $urandom;
      d.seq_increment = pick_inc();
      return d;
   endfunction

   task automatic add_random(int n);
      dgram_t d;
      int     k;
      int     r;
      bit [31:0] nxt;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (flow_cnt == 0 || r < 15) begin
            d = fresh_exporter();
            if (flow_cnt < 64) flows[flow_cnt++] = d;
            else flows[$urandom_range(63)] = d;
         end else if (r < 20) begin
            d = fresh_exporter();        // one-off noise, never tracked
            d.hash_salt = $urandom;
         end else begin
            k = $urandom_range(flow_cnt - 1);
            d = flows[k];
            if (!d.is_v6) begin
               d.addr_high = {$urandom, $urandom};
               d.addr_low[63:32] = $urandom;
            end
            if ($urandom_range(9) == 0) d.seq_increment = pick_inc();
            nxt = d.seq_number + d.seq_increment;
            case ($urandom_range(9))
               6: d.seq_number = nxt + 1 + $urandom_range(100);
               7: d.seq_number = nxt - 1 - $urandom_range(100);
               8: d.seq_number = 32'd0;
               9: d.seq_number = $urandom;
               default: d.seq_number = nxt;
            endcase
            d.byte_count = $urandom;
            flows[k] = d;
         end
         send_q.push_back(d);
      end
   endtask

   function automatic dgram_t mk(bit v6, bit [63:0] ah, bit [63:0] al, bit [31:0] i1,
                                 bit [31:0] i2, bit [31:0] salt, bit [31:0] sq,
                                 bit [31:0] by, bit [31:0] inc);
      dgram_t d;
      d.is_v6 = v6; d.addr_high = ah; d.addr_low = al; d.ident_one = i1;
      d.ident_two = i2; d.hash_salt = salt; d.seq_number = sq;
      d.byte_count = by; d.seq_increment = inc;
      return d;
   endfunction

   // main sequence
   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = 1'b0;
      csr_wr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.is_v6 = 1'b0;
      req_ch.addr_high = '0;
      req_ch.addr_low = '0;
      req_ch.ident_one = '0;
      req_ch.ident_two = '0;
      req_ch.hash_salt = '0;
      req_ch.seq_number = '0;
      req_ch.byte_count = '0;
      req_ch.seq_increment = '0;
      rsp_ch.ready = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // no room at all: every lookup misses and reports full
      csr_write(esst_pkg::CSR_MAX_ENTRIES, 9'd0);
      send_q.push_back(mk(0, 0, 0, 0, 0, 0, 5, 10, 1));
      send_q.push_back(mk(1, '1, '1, '1, '1, '1, '1, '1, '1));
      drain();

      csr_write(esst_pkg::CSR_MAX_ENTRIES, 9'd256);
      csr_write(esst_pkg::CSR_DISABLE, 9'd0);
      // v4: upper address bits must not matter, stored zero seq counts good
      send_q.push_back(mk(0, 64'h1234, 64'hAAAA_0000_0000_0001, 7, 8, 0, 100, 1, 10));
      send_q.push_back(mk(0, 64'h9999, 64'h5555_0000_0000_0001, 7, 8, 0, 110, 2, 10));
      send_q.push_back(mk(0, 0, 64'h1, 7, 8, 0, 200, 3, 10));
      send_q.push_back(mk(0, 0, 64'h1, 7, 8, 0, 150, 4, 10));
      // same low address as v6 and other idents: separate entries, same chain
      send_q.push_back(mk(1, 0, 64'h1, 7, 8, 0, 1, 5, 1));
      send_q.push_back(mk(0, 0, 64'h1, 7, 9, 0, 1, 6, 1));
      send_q.push_back(mk(0, 0, 64'h1, 6, 8, 0, 1, 7, 1));
      send_q.push_back(mk(0, 0, 64'h101, 6, 8, 0, 1, 7, 1));
      send_q.push_back(mk(0, 0, 64'h1, 6, 8, 0, 2, 7, 1));
      // sequence wrap, all-ones values
      send_q.push_back(mk(1, '1, '1, '1, '1, '1, 32'hFFFF_FFFF, '1, '1));
      send_q.push_back(mk(1, '1, '1, '1, '1, '1, 32'hFFFF_FFFE, '1, '1));
      send_q.push_back(mk(1, '1, '1, '1, '1, '1, 32'hFFFF_FFFF, '1, 32'h2));
      send_q.push_back(mk(1, '1, '1, '1, '1, '1, 32'h0, '1, 32'h1));
      send_q.push_back(mk(1, '1, '1, '1, '1, '1, 32'h5, 0, 32'h1));
      send_q.push_back(mk(1, '1, '1, '1, '1, '1, 32'h6, 0, 32'h0));
      send_idle_pct = 22;
      recv_stall_pct = 80;
      add_random(430);
      drain();

      csr_write(esst_pkg::CSR_DISABLE, 9'd1);
      send_idle_pct = 80;
      recv_stall_pct = 22;
      add_random(200);
      drain();

      csr_write(esst_pkg::CSR_DISABLE, 9'd0);
      csr_write(esst_pkg::CSR_MAX_ENTRIES, 9'd511);
      add_random(500);
      drain();

      csr_write(esst_pkg::CSR_MAX_ENTRIES, 9'd300);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      add_random(400);
      drain();

      // shrink below the allocated count: only hits still update
      csr_write(esst_pkg::CSR_MAX_ENTRIES, 9'd1);
      add_random(150);
      drain();

      if (err_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   // hang guard
   initial begin
      #40_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/esst_pkg.sv
rtl/core/esst_if.sv
rtl/core/esst_ram.sv
rtl/core/esst_update.sv
rtl/core/exporter_seq_status_table.sv
test/tb_top.sv
